FILE: rtl/core/mspt_pkg.sv
// ----------------------------------------------------------------------------
// mspt_pkg
// Shared constants, request codes and the control/status structs of the
// multi-slot periodic timer.
// ----------------------------------------------------------------------------
package mspt_pkg;

  localparam int NUM_SLOTS   = 8;
  localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int USED_W      = $clog2(NUM_SLOTS + 1);
  localparam int CNT_W       = 16;
  localparam int PRE_W       = 8;
  localparam int REQ_W       = 3;
  localparam int PORT_W      = 2;
  localparam int HIT_W       = 11;
  localparam int TIMER_HIT_W = 8;
  localparam int PIN_HIT_W   = 3;
  localparam int SLOT_OUT_W  = 3;
  localparam int APB_DW      = 32;
  localparam int APB_AW      = 3;

  localparam logic [PRE_W-1:0] PRESCALE_RESET = 8'd25;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK  = 3'd0,
    REQ_ADD   = 3'd1,
    REQ_READ  = 3'd2,
    REQ_PIN   = 3'd3,
    REQ_CLEAR = 3'd4
  } req_e;

  typedef enum logic [PORT_W-1:0] {
    PIN_GRP0 = 2'd0,
    PIN_GRP1 = 2'd1,
    PIN_GRP2 = 2'd2
  } pin_grp_e;

  typedef struct packed {
    logic             step;
    logic             add;
    logic             clr_hits;
    logic             clr_all;
    logic [CNT_W-1:0] period;
  } slot_ctl_t;

  typedef struct packed {
    logic [USED_W-1:0]    used;
    logic                 full;
    logic [NUM_SLOTS-1:0] hits;
  } slot_sts_t;

endpackage

FILE: rtl/core/mspt_req_if.sv
// ----------------------------------------------------------------------------
// mspt_req_if
// Request channel: valid/ready handshake with the request payload.
// ----------------------------------------------------------------------------
interface mspt_req_if;
  import mspt_pkg::*;

  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [CNT_W-1:0]    period;
  logic [CNT_W-1:0]    handler;
  logic [PORT_W-1:0]   pin_port;

  modport source (output valid, req_type, period, handler, pin_port, input ready);
  modport sink   (input valid, req_type, period, handler, pin_port, output ready);

endinterface

FILE: rtl/core/mspt_rsp_if.sv
// ----------------------------------------------------------------------------
// mspt_rsp_if
// Response channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
interface mspt_rsp_if;
  import mspt_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [HIT_W-1:0]      hit_flags;
  logic                  accepted;
  logic [SLOT_OUT_W-1:0] slot;

  modport source (output valid, hit_flags, accepted, slot, input ready);
  modport sink   (input valid, hit_flags, accepted, slot, output ready);

endinterface

FILE: rtl/core/mspt_apb_regs.sv
// ----------------------------------------------------------------------------
// mspt_apb_regs
// APB register file holding the prescale setting (register 0).
// ----------------------------------------------------------------------------
module mspt_apb_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mspt_pkg::APB_AW-1:0] paddr,
  input  logic [mspt_pkg::APB_DW-1:0] pwdata,
  output logic [mspt_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output logic [mspt_pkg::PRE_W-1:0]  prescale_o
);
  import mspt_pkg::*;

  logic [PRE_W-1:0] prescale_q;
  logic [PRE_W-1:0] prescale_d;
  logic             sel_reg0;

  // word index is paddr[2]; byte lanes ignored
  assign sel_reg0 = (paddr[2] == 1'b0);

  always_comb begin
    prescale_d = prescale_q;
    if (psel && penable && pwrite && sel_reg0) begin
      prescale_d = pwdata[PRE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_q <= PRESCALE_RESET;
    end else begin
      prescale_q <= prescale_d;
    end
  end

  assign prdata     = sel_reg0 ? APB_DW'(prescale_q) : '0;
  assign pready     = 1'b1;
  assign prescale_o = prescale_q;

endmodule

FILE: rtl/core/mspt_slot_table.sv
// ----------------------------------------------------------------------------
// mspt_slot_table
// Slot periods and counters, fill count and timer hit bits. All filled
// counters advance together on a timer step.
// ----------------------------------------------------------------------------
module mspt_slot_table (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mspt_pkg::slot_ctl_t   ctl_i,
  output mspt_pkg::slot_sts_t   sts_o
);
  import mspt_pkg::*;

  logic [CNT_W-1:0]     cnt_q [NUM_SLOTS];
  logic [CNT_W-1:0]     cnt_d [NUM_SLOTS];
  logic [CNT_W-1:0]     per_q [NUM_SLOTS];
  logic [CNT_W-1:0]     per_d [NUM_SLOTS];
  logic [USED_W-1:0]    used_q;
  logic [USED_W-1:0]    used_d;
  logic [NUM_SLOTS-1:0] hits_q;
  logic [NUM_SLOTS-1:0] hits_d;
  logic [SLOT_W-1:0]    wr_idx;

  assign wr_idx = used_q[SLOT_W-1:0];

  always_comb begin
    logic [CNT_W-1:0] inc;
    inc    = '0;
    cnt_d  = cnt_q;
    per_d  = per_q;
    used_d = used_q;
    hits_d = hits_q;
    if (ctl_i.step) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (USED_W'(i) < used_q) begin
          inc = cnt_q[i] + CNT_W'(1);
          if (inc < per_q[i]) begin
            cnt_d[i] = inc;
          end else begin
            // period reached: flag and restart
            cnt_d[i]  = '0;
            hits_d[i] = 1'b1;
          end
        end
      end
    end
    if (ctl_i.add) begin
      cnt_d[wr_idx] = '0;
      per_d[wr_idx] = ctl_i.period;
      used_d        = used_q + USED_W'(1);
    end
    if (ctl_i.clr_hits || ctl_i.clr_all) begin
      hits_d = '0;
    end
    if (ctl_i.clr_all) begin
      used_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      hits_q <= '0;
    end else begin
      used_q <= used_d;
      hits_q <= hits_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    per_q <= per_d;
  end

  assign sts_o.used = used_q;
  assign sts_o.full = (used_q == USED_W'(NUM_SLOTS));
  assign sts_o.hits = hits_q;

endmodule

FILE: rtl/core/multi_slot_periodic_timer.sv
// ----------------------------------------------------------------------------
// multi_slot_periodic_timer
// Table of periodic timer slots behind a shared prescaler, with pin hit bits.
// ----------------------------------------------------------------------------
// Every request gives exactly one response. The block takes one request per
// cycle while the response is not stalled; a request is held in the input
// register, and its state update and response are formed once the result
// register can take it and are held there until transferred. Each request
// makes a single state update: all filled slot counters advance with it on a
// prescaler wrap. Base ticks wrap the prescaler after prescale_ticks ticks
// (register 0 at byte address 0, reset 25; 0 behaves as 1). Add requests with
// a zero handler or a full table return accepted = 0. A read returns and clears
// all hit bits; clear-all empties the table and the hit bits but keeps the
// prescaler count.
module multi_slot_periodic_timer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mspt_pkg::APB_AW-1:0] paddr,
  input  logic [mspt_pkg::APB_DW-1:0] pwdata,
  output logic [mspt_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  mspt_req_if.sink                    req_i,
  mspt_rsp_if.source                  rsp_o
);
  import mspt_pkg::*;

  logic [PRE_W-1:0]      prescale;
  slot_ctl_t             ctl;
  slot_sts_t             sts;

  logic                  in_vld_q;
  logic                  in_vld_d;
  logic [REQ_W-1:0]      req_q;
  logic [CNT_W-1:0]      period_q;
  logic [CNT_W-1:0]      handler_q;
  logic [PORT_W-1:0]     port_q;
  logic                  adv;

  logic [PRE_W-1:0]      pre_q;
  logic [PRE_W-1:0]      pre_d;
  logic [PRE_W:0]        pre_next;
  logic [PIN_HIT_W-1:0]  pin_q;
  logic [PIN_HIT_W-1:0]  pin_d;

  logic                  out_vld_q;
  logic                  out_vld_d;
  logic [HIT_W-1:0]      flags_q;
  logic [HIT_W-1:0]      flags_d;
  logic                  acc_q;
  logic                  acc_d;
  logic [SLOT_OUT_W-1:0] slot_q;
  logic [SLOT_OUT_W-1:0] slot_d;

  mspt_apb_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .prescale_o (prescale)
  );

  mspt_slot_table u_slots (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .sts_o  (sts)
  );

  // process the held request whenever the result register can take it
  assign adv         = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || adv;

  always_comb begin
    in_vld_d = in_vld_q;
    if (req_i.ready) begin
      in_vld_d = req_i.valid;
    end
  end

  assign pre_next = {1'b0, pre_q} + (PRE_W + 1)'(1);

  always_comb begin
    ctl        = '0;
    ctl.period = period_q;
    pre_d      = pre_q;
    pin_d      = pin_q;
    flags_d    = flags_q;
    acc_d      = acc_q;
    slot_d     = slot_q;
    out_vld_d  = out_vld_q;
    if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
    if (adv) begin
      out_vld_d = 1'b1;
      flags_d   = '0;
      acc_d     = 1'b0;
      slot_d    = '0;
      unique case (req_e'(req_q))
        REQ_TICK: begin
          if (pre_next < {1'b0, prescale}) begin
            pre_d = pre_next[PRE_W-1:0];
          end else begin
            pre_d    = '0;
            ctl.step = 1'b1;
          end
        end
        REQ_ADD: begin
          if (handler_q != '0 && !sts.full) begin
            ctl.add = 1'b1;
            acc_d   = 1'b1;
            slot_d  = SLOT_OUT_W'(sts.used[SLOT_W-1:0]);
          end
        end
        REQ_READ: begin
          flags_d      = {pin_q, TIMER_HIT_W'(sts.hits)};
          ctl.clr_hits = 1'b1;
          pin_d        = '0;
        end
        REQ_PIN: begin
          unique case (pin_grp_e'(port_q))
            PIN_GRP0: pin_d = pin_q | 3'b001;
            PIN_GRP1: pin_d = pin_q | 3'b010;
            PIN_GRP2: pin_d = pin_q | 3'b100;
            default:  pin_d = pin_q;
          endcase
        end
        REQ_CLEAR: begin
          ctl.clr_all = 1'b1;
          pin_d       = '0;
        end
        default: begin
          // unused codes: drop, answer with zeros
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      pre_q     <= '0;
      pin_q     <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      pre_q     <= pre_d;
      pin_q     <= pin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      req_q     <= req_i.req_type;
      period_q  <= req_i.period;
      handler_q <= req_i.handler;
      port_q    <= req_i.pin_port;
    end
    flags_q <= flags_d;
    acc_q   <= acc_d;
    slot_q  <= slot_d;
  end

  assign rsp_o.valid     = out_vld_q;
  assign rsp_o.hit_flags = flags_q;
  assign rsp_o.accepted  = acc_q;
  assign rsp_o.slot      = slot_q;

  a_used_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.used <= USED_W'(NUM_SLOTS))
    else $error("slot fill count exceeds table size");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && req_q == REQ_CLEAR) |=> (sts.used == '0 && sts.hits == '0 && pin_q == '0))
    else $error("clear-all left table or hits set");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_vld_q && !rsp_o.ready) |=> (in_vld_q && $stable(req_q)))
    else $error("held request lost while response stalled");

  a_add_no_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.accepted) |-> (rsp_o.hit_flags == '0))
    else $error("accepted add carries hit flags");

endmodule
